// File: src/mplm_pkg.sv
// Package for the multi-pattern line matcher: sizes, operation codes and the
// structs passed between the matcher modules. Depends on nothing else.
package mplm_pkg;

   localparam int PATTERN_SLOTS   = 4;
   localparam int MAX_PATTERN_LEN = 16;

   localparam int OP_W    = 2;
   localparam int SLOT_W  = $clog2(PATTERN_SLOTS);
   localparam int POS_W   = $clog2(MAX_PATTERN_LEN);
   localparam int LEN_W   = $clog2(MAX_PATTERN_LEN + 1);
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 32;

   localparam logic [OP_W-1:0] OP_TEXT     = 2'd0;
   localparam logic [OP_W-1:0] OP_PAT_BYTE = 2'd1;
   localparam logic [OP_W-1:0] OP_PAT_LEN  = 2'd2;
   localparam logic [OP_W-1:0] OP_EOF      = 2'd3;

   localparam logic [BYTE_W-1:0]  NEWLINE_BYTE = 8'h0A;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
   localparam logic [LEN_W-1:0]   LEN_MAX      = LEN_W'(MAX_PATTERN_LEN);

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [SLOT_W-1:0] pattern_slot;
      logic [POS_W-1:0]  pattern_position;
      logic [BYTE_W-1:0] byte_value;
      logic [LEN_W-1:0]  pattern_length;
   } req_item_type;

   typedef struct packed {
      logic [COUNT_W-1:0] line_number;
      logic               line_selected;
      logic               pattern_found;
      logic [COUNT_W-1:0] selected_count;
      logic               any_selected;
   } rsp_item_type;

   // Window of the most recent line bytes; entry 0 is the newest byte.
   typedef struct packed {
      logic [MAX_PATTERN_LEN-1:0][BYTE_W-1:0] bytes;
      logic [LEN_W-1:0]                       count;
   } window_type;

endpackage

// File: src/mplm_pattern_bank.sv
// Pattern slots (bytes and lengths) and the parallel comparators that test
// every enabled slot against the updated text window. Uses mplm_pkg.
module mplm_pattern_bank
   import mplm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  window_type   win,
   output logic         any_match
);

   logic [BYTE_W-1:0] pat_ff [PATTERN_SLOTS][MAX_PATTERN_LEN];
   logic [LEN_W-1:0]  len_ff [PATTERN_SLOTS];
   logic [LEN_W-1:0]  len_in;
   logic [PATTERN_SLOTS-1:0] slot_hit;
   logic              slot_ok;
   logic [LEN_W-1:0]  tap;

   assign len_in = (item.pattern_length > LEN_MAX) ? LEN_MAX : item.pattern_length;

   // Pattern bytes have no reset; load them before enabling their slot (unchecked).
   always_ff @(posedge clock) begin
      if (fire && item.operation == OP_PAT_BYTE) begin
         pat_ff[item.pattern_slot][item.pattern_position] <= item.byte_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PATTERN_SLOTS; s++) begin
            len_ff[s] <= '0;
         end
      end else if (fire && item.operation == OP_PAT_LEN) begin
         len_ff[item.pattern_slot] <= len_in;
      end
   end

   // Pattern byte p lines up with window entry len-1-p.
   always_comb begin
      slot_hit = '0;
      slot_ok  = 1'b0;
      tap      = '0;
      for (int s = 0; s < PATTERN_SLOTS; s++) begin
         slot_ok = (len_ff[s] != '0) && (len_ff[s] <= win.count);
         for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
            tap = len_ff[s] - LEN_W'(p) - LEN_W'(1);
            if (LEN_W'(p) < len_ff[s] && pat_ff[s][p] != win.bytes[tap[POS_W-1:0]]) begin
               slot_ok = 1'b0;
            end
         end
         slot_hit[s] = slot_ok;
      end
   end

   assign any_match = |slot_hit;

endmodule

// File: src/mplm_line_state.sv
// Per-line and per-file state: text window, line hit flag and the saturating
// line counters, plus formation of the line result word. Uses mplm_pkg.
module mplm_line_state
   import mplm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  logic         invert_match,
   input  logic         any_match,
   output window_type   win_next,
   output logic         has_result,
   output rsp_item_type result
);

   window_type         win_ff;
   logic               hit_ff;
   logic               hit_in;
   logic [COUNT_W-1:0] seen_ff;
   logic [COUNT_W-1:0] seen_in;
   logic [COUNT_W-1:0] sel_ff;
   logic [COUNT_W-1:0] sel_in;
   logic               is_newline;
   logic               is_text;
   logic               found;
   logic               selected;

   // Shifted window as it stands after this byte; the comparators look at it.
   always_comb begin
      win_next.bytes[0] = item.byte_value;
      for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
         win_next.bytes[k] = win_ff.bytes[k-1];
      end
      win_next.count = (win_ff.count == LEN_MAX) ? win_ff.count : win_ff.count + LEN_W'(1);
   end

   assign is_text    = (item.operation == OP_TEXT);
   assign is_newline = is_text && (item.byte_value == NEWLINE_BYTE);
   assign found      = hit_ff;
   assign selected   = found ^ invert_match;
   assign hit_in     = hit_ff | any_match;
   assign seen_in    = (seen_ff == COUNT_MAX) ? seen_ff : seen_ff + COUNT_W'(1);
   assign sel_in     = (selected && sel_ff != COUNT_MAX) ? sel_ff + COUNT_W'(1) : sel_ff;

   always_comb begin
      case (item.operation)
         OP_TEXT: has_result = is_newline;
         OP_EOF:  has_result = (win_ff.count != '0);
         default: has_result = 1'b0;
      endcase
   end

   assign result.line_number    = seen_in;
   assign result.line_selected  = selected;
   assign result.pattern_found  = found;
   assign result.selected_count = sel_in;
   assign result.any_selected   = (sel_in != '0);

   // Window bytes need no reset: only the first count entries are ever compared.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.count <= '0;
         hit_ff       <= 1'b0;
         seen_ff      <= '0;
         sel_ff       <= '0;
      end else if (fire) begin
         if (is_newline) begin
            win_ff.count <= '0;
            hit_ff       <= 1'b0;
            seen_ff      <= seen_in;
            sel_ff       <= sel_in;
         end else if (is_text) begin
            win_ff.bytes <= win_next.bytes;
            win_ff.count <= win_next.count;
            hit_ff       <= hit_in;
         end else if (item.operation == OP_EOF) begin
            win_ff.count <= '0;
            hit_ff       <= 1'b0;
            seen_ff      <= '0;
            sel_ff       <= '0;
         end
      end
   end

endmodule

// File: src/multi_pattern_line_matcher_unit.sv
// Top level of the multi-pattern line matcher: input register, output register
// and handshakes. Uses mplm_pkg, mplm_pattern_bank and mplm_line_state.
//
// Usage: every req_ word carries one operation: a text byte, a pattern byte
// write, a pattern length write, or end of file. Patterns are loaded through
// the same channel, so they take effect in stream order. A newline byte, or
// end of file after a partial line, yields one rsp_ word with the line number,
// the match and select flags and the selected-line count of the current file.
// All other words yield nothing. csr_write_enable writes invert_match at once;
// it is meant to change only while no line result is outstanding.
//
// Throughput is one word per cycle while no result is held back: the window,
// all slot comparators and the counter updates sit between the input register
// and the output register. rsp_valid rises when a word's result is written
// into the output register from the input register. When rsp_ready is low a
// finished result waits in the output register; one more word is still taken
// into the input register, and words that give no result keep flowing until
// a second result is ready. Reset clears the pattern lengths (all slots off),
// the line state, the counters and invert_match; pattern bytes are not reset.
module multi_pattern_line_matcher_unit
   import mplm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [SLOT_W-1:0]   req_pattern_slot,
   input  logic [POS_W-1:0]    req_pattern_position,
   input  logic [BYTE_W-1:0]   req_byte_value,
   input  logic [LEN_W-1:0]    req_pattern_length,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COUNT_W-1:0]  rsp_line_number,
   output logic                rsp_line_selected,
   output logic                rsp_pattern_found,
   output logic [COUNT_W-1:0]  rsp_selected_count,
   output logic                rsp_any_selected,
   input  logic                csr_write_enable,
   input  logic                csr_write_data
);

   req_item_type s1_item_ff;
   req_item_type s1_item_in;
   logic         s1_valid_ff;
   logic         s1_valid_in;
   logic         s1_fire;
   logic         req_accept;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type result;
   logic         has_result;
   logic         any_match;
   logic         invert_ff;
   window_type   win_next;

   assign s1_item_in.operation        = req_operation;
   assign s1_item_in.pattern_slot     = req_pattern_slot;
   assign s1_item_in.pattern_position = req_pattern_position;
   assign s1_item_in.byte_value       = req_byte_value;
   assign s1_item_in.pattern_length   = req_pattern_length;

   // The staged word may retire unless it makes a result and the output is full and not being read.
   assign s1_fire    = s1_valid_ff && (!has_result || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_fire;
   assign req_accept = req_valid && req_ready;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = (s1_fire && has_result) ? 1'b1
                       : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         invert_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            invert_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= s1_item_in;
      end
      if (s1_fire && has_result) begin
         rsp_item_ff <= result;
      end
   end

   mplm_pattern_bank u_bank (
      .clock     (clock),
      .reset     (reset),
      .fire      (s1_fire),
      .item      (s1_item_ff),
      .win       (win_next),
      .any_match (any_match)
   );

   mplm_line_state u_line (
      .clock        (clock),
      .reset        (reset),
      .fire         (s1_fire),
      .item         (s1_item_ff),
      .invert_match (invert_ff),
      .any_match    (any_match),
      .win_next     (win_next),
      .has_result   (has_result),
      .result       (result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_number    = rsp_item_ff.line_number;
   assign rsp_line_selected  = rsp_item_ff.line_selected;
   assign rsp_pattern_found  = rsp_item_ff.pattern_found;
   assign rsp_selected_count = rsp_item_ff.selected_count;
   assign rsp_any_selected   = rsp_item_ff.any_selected;

   // A staged word that cannot retire must stay staged and unchanged.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("staged word lost or changed while blocked");

   a_select_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_item_ff.line_selected ==
                       (rsp_item_ff.pattern_found ^ invert_ff))
      else $error("line_selected disagrees with pattern_found and invert_match");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_item_ff.selected_count <= rsp_item_ff.line_number)
      else $error("selected count exceeds line number");

   a_any_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_item_ff.any_selected == (rsp_item_ff.selected_count != '0))
      else $error("any_selected disagrees with selected_count");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_pattern_line_matcher_unit: a directed table, then random
// pattern loads, lines and noise; each result checked against a table row or in-bench tracker.
// Depends on mplm_pkg and the matcher RTL.
module testbench;
   import mplm_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASES      = 5;
   localparam int PHASE_WORDS = 200;

   typedef struct packed {
      req_item_type word;
      logic         typed;
      rsp_item_type line;
   } table_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [OP_W-1:0]    req_operation;
   logic [SLOT_W-1:0]  req_pattern_slot;
   logic [POS_W-1:0]   req_pattern_position;
   logic [BYTE_W-1:0]  req_byte_value;
   logic [LEN_W-1:0]   req_pattern_length;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [COUNT_W-1:0] rsp_line_number;
   logic               rsp_line_selected;
   logic               rsp_pattern_found;
   logic [COUNT_W-1:0] rsp_selected_count;
   logic               rsp_any_selected;
   logic               csr_write_enable;
   logic               csr_write_data;

   multi_pattern_line_matcher_unit u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_pattern_slot     (req_pattern_slot),
      .req_pattern_position (req_pattern_position),
      .req_byte_value       (req_byte_value),
      .req_pattern_length   (req_pattern_length),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_line_number      (rsp_line_number),
      .rsp_line_selected    (rsp_line_selected),
      .rsp_pattern_found    (rsp_pattern_found),
      .rsp_selected_count   (rsp_selected_count),
      .rsp_any_selected     (rsp_any_selected),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   rsp_item_type pending_lines [$];
   int           failures      = 0;
   int           lines_checked = 0;
   int           words_sent    = 0;
   int           cycle_count   = 0;
   bit           calm          = 0;

   // Tracked matcher state.
   logic [BYTE_W-1:0]  pat_bytes   [PATTERN_SLOTS][MAX_PATTERN_LEN];
   bit                 pat_written [PATTERN_SLOTS][MAX_PATTERN_LEN];
   logic [LEN_W-1:0]   pat_len     [PATTERN_SLOTS];
   logic [BYTE_W-1:0]  recent      [MAX_PATTERN_LEN];
   logic [LEN_W-1:0]   line_fill;
   bit                 line_hit;
   bit                 invert_sel;
   logic [COUNT_W-1:0] line_count;
   logic [COUNT_W-1:0] select_count;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic bit slot_hit(int s);
      int len;
      int p;
      len = int'(pat_len[s]);
      if (len == 0 || len > line_fill) return 0;
      for (p = 0; p < len; p++)
         if (pat_bytes[s][p] != recent[len-1-p]) return 0;
      return 1;
   endfunction

   function automatic rsp_item_type end_line();
      rsp_item_type r;
      bit           sel;
      int           i;
      sel = line_hit ^ invert_sel;
      if (line_count != COUNT_MAX) line_count++;
      if (sel && select_count != COUNT_MAX) select_count++;
      r.line_number    = line_count;
      r.line_selected  = sel;
      r.pattern_found  = line_hit;
      r.selected_count = select_count;
      r.any_selected   = (select_count != 0);
      for (i = 0; i < MAX_PATTERN_LEN; i++) recent[i] = '0;
      line_fill = '0;
      line_hit  = 0;
      return r;
   endfunction

   // Advances the tracked state by one accepted word; returns 1 when a line result is due.
   function automatic bit track_word(req_item_type w, output rsp_item_type r);
      bit got;
      int s;
      int i;
      got = 0;
      r   = '0;
      case (w.operation)
         OP_TEXT: begin
            if (w.byte_value == NEWLINE_BYTE) begin
               r   = end_line();
               got = 1;
            end else begin
               for (i = MAX_PATTERN_LEN - 1; i > 0; i--) recent[i] = recent[i-1];
               recent[0] = w.byte_value;
               if (line_fill < MAX_PATTERN_LEN) line_fill++;
               for (s = 0; s < PATTERN_SLOTS; s++)
                  if (slot_hit(s)) line_hit = 1;
            end
         end
         OP_PAT_BYTE: begin
            pat_bytes[w.pattern_slot][w.pattern_position]   = w.byte_value;
            pat_written[w.pattern_slot][w.pattern_position] = 1;
         end
         OP_PAT_LEN: begin
            pat_len[w.pattern_slot] = (w.pattern_length > LEN_MAX) ? LEN_MAX : w.pattern_length;
         end
         OP_EOF: begin
            // The window is already clear whenever the line is empty.
            if (line_fill != 0) begin
               r   = end_line();
               got = 1;
            end
            line_count   = '0;
            select_count = '0;
         end
         default: ;
      endcase
      return got;
   endfunction

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_byte(bit newline_ok);
      int                r;
      logic [BYTE_W-1:0] b;
      r = $urandom_range(0, 99);
      if (r < 70)      b = 8'h61 + BYTE_W'($urandom_range(0, 3));
      else if (r < 76) b = 8'h00;
      else if (r < 82) b = 8'hFF;
      else             b = BYTE_W'($urandom_range(0, 255));
      if (b == NEWLINE_BYTE && !newline_ok) b = 8'h0B;
      return b;
   endfunction

   // Every field random; callers overwrite the ones the operation uses.
   function automatic req_item_type noise_fields(logic [OP_W-1:0] op);
      req_item_type w;
      w.operation        = op;
      w.pattern_slot     = SLOT_W'($urandom);
      w.pattern_position = POS_W'($urandom);
      w.byte_value       = BYTE_W'($urandom);
      w.pattern_length   = LEN_W'($urandom);
      return w;
   endfunction

   // A length may only cover pattern bytes that have been written.
   function automatic logic [LEN_W-1:0] legal_length(int s);
      int p;
      p = 0;
      while (p < MAX_PATTERN_LEN && pat_written[s][p]) p++;
      if (p == MAX_PATTERN_LEN) return LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
      return LEN_W'($urandom_range(0, p));
   endfunction

   function automatic table_row_type table_row(logic [OP_W-1:0] op, int slot, int pos,
                                               logic [BYTE_W-1:0] b,
                                               int len, bit typed = 0,
                                               rsp_item_type line = '0);
      table_row_type t;
      t.word.operation        = op;
      t.word.pattern_slot     = SLOT_W'(slot);
      t.word.pattern_position = POS_W'(pos);
      t.word.byte_value       = b;
      t.word.pattern_length   = LEN_W'(len);
      t.typed                 = typed;
      t.line                  = line;
      return t;
   endfunction

   task automatic send_word(req_item_type w, bit typed = 0, rsp_item_type typed_line = '0);
      int           gap;
      rsp_item_type r;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1;
      req_operation        <= w.operation;
      req_pattern_slot     <= w.pattern_slot;
      req_pattern_position <= w.pattern_position;
      req_byte_value       <= w.byte_value;
      req_pattern_length   <= w.pattern_length;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (track_word(w, r)) pending_lines.push_back(typed ? typed_line : r);
   endtask

   task automatic send_text(logic [BYTE_W-1:0] b);
      req_item_type w;
      w = noise_fields(OP_TEXT);
      w.byte_value = b;
      send_word(w);
   endtask

   task automatic load_pattern();
      int           s;
      int           n;
      int           p;
      int           r;
      req_item_type w;
      s = $urandom_range(0, PATTERN_SLOTS - 1);
      r = $urandom_range(0, 99);
      if (r < 10)      n = 0;
      else if (r < 65) n = $urandom_range(1, 4);
      else if (r < 88) n = $urandom_range(5, MAX_PATTERN_LEN - 1);
      else             n = MAX_PATTERN_LEN;
      for (p = 0; p < n; p++) begin
         w = noise_fields(OP_PAT_BYTE);
         w.pattern_slot     = SLOT_W'(s);
         w.pattern_position = POS_W'(p);
         w.byte_value       = pick_byte($urandom_range(0, 49) == 0);
         send_word(w);
      end
      w = noise_fields(OP_PAT_LEN);
      w.pattern_slot = SLOT_W'(s);
      // A full pattern also gets the oversized lengths that saturate.
      if (n == MAX_PATTERN_LEN)
         w.pattern_length = LEN_W'($urandom_range(MAX_PATTERN_LEN, (1 << LEN_W) - 1));
      else
         w.pattern_length = LEN_W'(n);
      send_word(w);
   endtask

   task automatic send_line();
      int           n;
      int           i;
      int           p;
      int           at;
      int           s;
      int           len;
      req_item_type w;
      n   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
      s   = $urandom_range(0, PATTERN_SLOTS - 1);
      len = int'(pat_len[s]);
      at  = ($urandom_range(0, 1) == 1 && len > 0) ? $urandom_range(0, n) : -1;
      for (i = 0; i <= n; i++) begin
         if (i == at)
            for (p = 0; p < len; p++) send_text(pat_bytes[s][p]);
         if (i < n) send_text(pick_byte(0));
      end
      w = noise_fields(($urandom_range(0, 9) == 0) ? OP_EOF : OP_TEXT);
      if (w.operation == OP_TEXT) w.byte_value = NEWLINE_BYTE;
      send_word(w);
   endtask

   task automatic send_noise();
      req_item_type w;
      w = noise_fields(OP_W'($urandom_range(0, 3)));
      if (w.operation == OP_PAT_LEN) w.pattern_length = legal_length(int'(w.pattern_slot));
      send_word(w);
   endtask

   task automatic write_invert(bit v);
      req_valid <= 0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      invert_sel = v;
   endtask

   task automatic compare_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : check_lines
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lines.size() == 0) begin
            $error("line result with none expected: line_number %0d", rsp_line_number);
            failures++;
         end else begin
            want = pending_lines.pop_front();
            lines_checked++;
            compare_field("line_number", want.line_number, rsp_line_number);
            compare_field("line_selected", COUNT_W'(want.line_selected),
                          COUNT_W'(rsp_line_selected));
            compare_field("pattern_found", COUNT_W'(want.pattern_found),
                          COUNT_W'(rsp_pattern_found));
            compare_field("selected_count", want.selected_count, rsp_selected_count);
            compare_field("any_selected", COUNT_W'(want.any_selected),
                          COUNT_W'(rsp_any_selected));
         end
      end
   end

   initial begin : drive_ready
      int stall;
      rsp_ready = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         rsp_ready <= 1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         stall = idle_cycles();
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin : drive_words
      table_row_type directed [$];
      int            i;
      int            s;
      int            phase;
      int            target;
      int            r;
      bit            modes [PHASES];

      reset                = 1;
      req_valid            = 0;
      req_operation        = OP_TEXT;
      req_pattern_slot     = '0;
      req_pattern_position = '0;
      req_byte_value       = '0;
      req_pattern_length   = '0;
      csr_write_enable     = 0;
      csr_write_data       = 0;
      for (s = 0; s < PATTERN_SLOTS; s++) begin
         pat_len[s] = '0;
         for (i = 0; i < MAX_PATTERN_LEN; i++) begin
            pat_bytes[s][i]   = '0;
            pat_written[s][i] = 0;
         end
      end
      for (i = 0; i < MAX_PATTERN_LEN; i++) recent[i] = '0;
      line_fill    = '0;
      line_hit     = 0;
      invert_sel   = 0;
      line_count   = '0;
      select_count = '0;

      // End of file on an empty line gives nothing; then a text byte with unused fields at their maximum.
      directed.push_back(table_row(OP_EOF, 0, 0, 8'h00, 0));
      directed.push_back(table_row(OP_TEXT, 3, 15, 8'h00, 31));
      directed.push_back(table_row(OP_TEXT, 0, 0, NEWLINE_BYTE, 0, 1,
                                   '{32'd1, 1'b0, 1'b0, 32'd0, 1'b0}));
      // Byte extremes in a two-byte pattern.
      directed.push_back(table_row(OP_PAT_BYTE, 0, 0, 8'h00, 0));
      directed.push_back(table_row(OP_PAT_BYTE, 0, 1, 8'hFF, 0));
      directed.push_back(table_row(OP_PAT_LEN, 0, 0, 8'h00, 2));
      directed.push_back(table_row(OP_TEXT, 0, 0, 8'h00, 0));
      directed.push_back(table_row(OP_TEXT, 0, 0, 8'hFF, 0));
      directed.push_back(table_row(OP_TEXT, 0, 0, NEWLINE_BYTE, 0, 1,
                                   '{32'd2, 1'b1, 1'b1, 32'd1, 1'b1}));
      // A pattern holding a newline can never match.
      directed.push_back(table_row(OP_PAT_BYTE, 1, 0, NEWLINE_BYTE, 0));
      directed.push_back(table_row(OP_PAT_LEN, 1, 0, 8'h00, 1));
      directed.push_back(table_row(OP_TEXT, 0, 0, 8'h41, 0));
      directed.push_back(table_row(OP_TEXT, 0, 0, NEWLINE_BYTE, 0));
      // Enabling and disabling a slot mid-line; the earlier hit must stick.
      directed.push_back(table_row(OP_PAT_BYTE, 2, 0, 8'h78, 0));
      directed.push_back(table_row(OP_TEXT, 0, 0, 8'h78, 0));
      directed.push_back(table_row(OP_PAT_LEN, 2, 0, 8'h00, 1));
      directed.push_back(table_row(OP_TEXT, 0, 0, 8'h78, 0));
      directed.push_back(table_row(OP_PAT_LEN, 2, 0, 8'h00, 0));
      directed.push_back(table_row(OP_TEXT, 0, 0, NEWLINE_BYTE, 0));
      // End of file closes a partial line, then numbering restarts.
      directed.push_back(table_row(OP_TEXT, 0, 0, 8'h42, 0));
      directed.push_back(table_row(OP_EOF, 0, 0, 8'h00, 0));
      directed.push_back(table_row(OP_TEXT, 0, 0, NEWLINE_BYTE, 0, 1,
                                   '{32'd1, 1'b0, 1'b0, 32'd0, 1'b0}));
      directed.push_back(table_row(OP_EOF, 3, 15, 8'hFF, 31));

      repeat (5) @(posedge clock);
      reset <= 0;
      write_invert(0);
      for (i = 0; i < directed.size(); i++)
         send_word(directed[i].word, directed[i].typed, directed[i].line);

      modes = '{1, 0, 1, 0, 1};
      modes[PHASES-1] = 1'($urandom_range(0, 1));
      for (phase = 0; phase < PHASES; phase++) begin
         write_invert(modes[phase]);
         calm   = (phase == 2);
         target = words_sent + PHASE_WORDS;
         while (words_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 8)       load_pattern();
            else if (r < 88) send_line();
            else             send_noise();
         end
      end

      req_valid <= 0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d words over %0d phases of match inversion; %0d line results checked.",
               words_sent, PHASES + 1, lines_checked);
      if (failures == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

// File: sim.f
src/mplm_pkg.sv
src/mplm_pattern_bank.sv
src/mplm_line_state.sv
src/multi_pattern_line_matcher_unit.sv
tb/sv/testbench.sv
